// ===== hdl/ymcrc_pkg.sv =====
// Shared types and constants for the YMODEM-CRC receiver.
`timescale 1ns / 1ps
`default_nettype none
package ymcrc_pkg;
  localparam int unsigned MaxRes = 4;
  localparam logic [7:0] BSoh = 8'h01;
  localparam logic [7:0] BStx = 8'h02;
  localparam logic [7:0] BEot = 8'h04;
  localparam logic [7:0] BAck = 8'h06;
  localparam logic [7:0] BNak = 8'h15;
  localparam logic [7:0] BCan = 8'h18;
  localparam logic [7:0] BReq = 8'h43;

  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgMaxErr  = 2'd1;
  localparam logic [1:0] CfgAbort1  = 2'd2;
  localparam logic [1:0] CfgAbort2  = 2'd3;

  typedef enum logic [2:0] {
    KSend = 3'd0, KData = 3'd1, KCommit = 3'd2, KDiscard = 3'd3,
    KStart = 3'd4, KEnd = 3'd5, KDone = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    SOk = 4'd0, STimeout = 4'd1, SUnknown = 4'd2, SSender = 4'd3, SUser = 4'd4,
    SSeqInv = 4'd5, SCrc = 4'd6, SMismatch = 4'd7, SInvalid = 4'd8, SSize = 4'd9
  } status_e;

  typedef enum logic [1:0] {PhIdle = 2'd0, PhBusy = 2'd1, PhDone = 2'd2} sess_e;
  typedef enum logic [2:0] {
    FrType = 3'd0, FrCan = 3'd1, FrSeq = 3'd2, FrComp = 3'd3,
    FrData = 3'd4, FrCrcH = 3'd5, FrCrcL = 3'd6
  } frame_e;
  typedef enum logic [1:0] {HdName = 2'd0, HdSize = 2'd1, HdClosed = 2'd2, HdEmpty = 2'd3} hdr_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   value_byte;
    logic [9:0]   data_index;
    logic [10:0]  valid_count;
    logic [31:0]  file_size;
    status_e      status;
    logic         last;
  } res_t;

  // group of up to four results produced by one request
  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MaxRes-1:0]     res;
  } bundle_t;

  // one CRC-16 step over a byte, poly 0x1021
  function automatic logic [15:0] crc_upd(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/ymcrc_front.sv =====
// Front end: frames each request, updates protocol state, builds result bundle.
`timescale 1ns / 1ps
`default_nettype none
module ymcrc_front #(
  parameter int unsigned NameMax = 64,
  parameter int unsigned SizeDigitsMax = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               take_i,
  input  wire logic               operation_i,
  input  wire logic [7:0]         rx_byte_i,
  output ymcrc_pkg::bundle_t      bundle_o
);
  import ymcrc_pkg::*;

  logic [23:0] tmo_q;
  logic [7:0]  maxerr_q, ab1_q, ab2_q;
  sess_e       sess_q, sess_d;
  logic [7:0]  eseq_q, eseq_d, errc_q, errc_d;
  logic [31:0] rtot_q, rtot_d, ftot_q, ftot_d;
  frame_e      fr_q, fr_d;
  logic        long_q, long_d, cok_q, cok_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] crc_q, crc_d, crcr_q, crcr_d;
  logic [10:0] pos_q, pos_d;
  logic [23:0] tick_q, tick_d;
  logic [31:0] acc_q, acc_d;
  hdr_e        hd_q, hd_d;
  logic [6:0]  hc_q, hc_d;
  bundle_t     bo;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= 24'd1000; maxerr_q <= 8'd5; ab1_q <= 8'd65; ab2_q <= 8'd97;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTimeout: tmo_q    <= cfg_data_i;
        CfgMaxErr:  maxerr_q <= cfg_data_i[7:0];
        CfgAbort1:  ab1_q    <= cfg_data_i[7:0];
        CfgAbort2:  ab2_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // next-state and result logic
  always_comb begin
    logic [2:0]  n;
    status_e     st;
    logic        busy;
    logic [10:0] blk;
    logic [31:0] rem;
    logic [10:0] vld;
    logic [35:0] prod;
    logic        do_err, do_clear;
    status_e     est;
    n = '0; st = SOk; busy = (sess_q == PhBusy);
    blk = long_q ? 11'd1024 : 11'd128;
    rem = ftot_q - rtot_q; vld = '0; prod = '0;
    do_err = 1'b0; do_clear = 1'b0; est = SOk;
    bo = '0;
    sess_d = sess_q; eseq_d = eseq_q; errc_d = errc_q; rtot_d = rtot_q; ftot_d = ftot_q;
    fr_d = fr_q; long_d = long_q; cok_d = cok_q; seq_d = seq_q; crc_d = crc_q;
    crcr_d = crcr_q; pos_d = pos_q; tick_d = tick_q; acc_d = acc_q; hd_d = hd_q; hc_d = hc_q;
    if (take_i && (sess_q == PhIdle || sess_q == PhBusy)) begin
      if (operation_i) begin
        tick_d = tick_q + 24'd1;
        if (tick_d >= tmo_q) begin
          tick_d = '0;
          if (busy && fr_q >= FrData) begin
            bo.res[n].kind = KDiscard; bo.res[n].status = STimeout; n = n + 3'd1;
          end
          do_clear = 1'b1; do_err = 1'b1; est = STimeout;
        end
      end else begin
        tick_d = '0;
        unique case (fr_q)
          FrType: begin
            if (rx_byte_i == BSoh || rx_byte_i == BStx) begin
              do_clear = 1'b1;
            end else if (rx_byte_i == BEot) begin
              bo.res[0].kind = KEnd;
              bo.res[1].kind = KSend; bo.res[1].value_byte = BAck;
              bo.res[2].kind = KSend; bo.res[2].value_byte = BReq;
              n = 3'd3;
              sess_d = PhIdle; eseq_d = '0; errc_d = '0; rtot_d = '0; ftot_d = '0;
            end else if (rx_byte_i == BCan) begin
              fr_d = FrCan;
            end else begin
              do_err = 1'b1;
              est = (rx_byte_i == ab1_q || rx_byte_i == ab2_q) ? SUser : SUnknown;
            end
          end
          FrCan: begin
            do_clear = 1'b1; do_err = 1'b1;
            est = (rx_byte_i == BCan) ? SSender : SUnknown;
          end
          FrSeq: begin seq_d = rx_byte_i; fr_d = FrComp; end
          FrComp: begin
            cok_d = ((rx_byte_i ^ 8'hFF) == seq_q); pos_d = '0; crc_d = '0; fr_d = FrData;
          end
          FrData: begin
            crc_d = crc_upd(crc_q, rx_byte_i);
            if (sess_q == PhIdle) begin
              if (hd_q == HdName) begin
                if (32'(hc_q) >= NameMax) begin hd_d = HdSize; hc_d = '0; end
                else if (rx_byte_i == 8'h00) begin
                  hd_d = (pos_q == '0) ? HdEmpty : HdSize; hc_d = '0;
                end else hc_d = hc_q + 7'd1;
              end else if (hd_q == HdSize) begin
                if (32'(hc_q) >= SizeDigitsMax || rx_byte_i < 8'h30 || rx_byte_i > 8'h39)
                  hd_d = HdClosed;
                else begin
                  prod = {4'd0, acc_q} * 36'd10 + 36'(rx_byte_i - 8'h30);
                  acc_d = (prod[35:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
                  hc_d = hc_q + 7'd1;
                end
              end
            end else begin
              bo.res[0].kind = KData; bo.res[0].value_byte = rx_byte_i;
              bo.res[0].data_index = pos_q[9:0]; n = 3'd1;
            end
            pos_d = pos_q + 11'd1;
            if (pos_d >= blk) fr_d = FrCrcH;
          end
          FrCrcH: begin crcr_d = {rx_byte_i, 8'h00}; fr_d = FrCrcL; end
          FrCrcL: begin
            do_clear = 1'b1;
            if (!cok_q) st = SSeqInv;
            else if (crc_q != {crcr_q[15:8], rx_byte_i}) st = SCrc;
            else if (seq_q != eseq_q) st = SMismatch;
            if (st == SOk && busy) begin
              if (rtot_q >= ftot_q) st = SInvalid;
              else begin
                vld = (rem < 32'(blk)) ? rem[10:0] : blk;
                rtot_d = rtot_q + 32'(vld); errc_d = '0; eseq_d = eseq_q + 8'd1;
                bo.res[0].kind = KCommit; bo.res[0].valid_count = vld;
                bo.res[1].kind = KSend; bo.res[1].value_byte = BAck; n = 3'd2;
              end
            end else if (st == SOk) begin
              if (hd_q == HdEmpty) begin
                bo.res[0].kind = KSend; bo.res[0].value_byte = BAck;
                bo.res[1].kind = KDone; n = 3'd2; sess_d = PhDone;
              end else if ((hd_q == HdSize || hd_q == HdClosed) && hc_q != '0) begin
                ftot_d = acc_q; sess_d = PhBusy; eseq_d = eseq_q + 8'd1;
                bo.res[0].kind = KStart; bo.res[0].file_size = acc_q;
                bo.res[1].kind = KSend; bo.res[1].value_byte = BAck;
                bo.res[2].kind = KSend; bo.res[2].value_byte = BReq; n = 3'd3;
              end else st = SSize;
            end
            if (st != SOk) begin
              if (busy) begin
                bo.res[0].kind = KDiscard; bo.res[0].status = st; n = 3'd1;
              end
              do_err = 1'b1; est = st;
            end
          end
          default: do_clear = 1'b1;
        endcase
      end
      if (do_clear) begin
        fr_d = FrType; long_d = 1'b0; seq_d = '0; cok_d = 1'b0; crc_d = '0; crcr_d = '0;
        pos_d = '0; acc_d = '0; hd_d = HdName; hc_d = '0;
        if (!operation_i && fr_q == FrType && (rx_byte_i == BSoh || rx_byte_i == BStx)) begin
          long_d = (rx_byte_i == BStx); fr_d = FrSeq;
        end
      end
      if (do_err) begin
        priority if (est == SMismatch) begin
          bo.res[n].kind = KSend; bo.res[n].value_byte = BNak; bo.res[n].status = est;
          n = n + 3'd1;
        end else if (est == SSender) begin
          bo.res[n].kind = KSend; bo.res[n].value_byte = BAck; bo.res[n].status = est;
          bo.res[n+3'd1].kind = KDone; bo.res[n+3'd1].status = est;
          n = n + 3'd2; sess_d = PhDone;
        end else begin
          if (est != SUser && busy && errc_q != 8'hFF) errc_d = errc_q + 8'd1;
          if (est == SUser || errc_d > maxerr_q) begin
            bo.res[n].kind = KSend; bo.res[n].value_byte = BCan; bo.res[n].status = est;
            bo.res[n+3'd1].kind = KSend; bo.res[n+3'd1].value_byte = BCan;
            bo.res[n+3'd1].status = est;
            bo.res[n+3'd2].kind = KDone; bo.res[n+3'd2].status = est;
            n = n + 3'd3; sess_d = PhDone;
          end else begin
            bo.res[n].kind = KSend; bo.res[n].value_byte = BReq; bo.res[n].status = est;
            n = n + 3'd1;
          end
        end
      end
    end
    bo.cnt = n;
    if (n != '0) bo.res[n-3'd1].last = 1'b1;
  end

  assign bundle_o = bo;

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q <= PhIdle; eseq_q <= '0; errc_q <= '0; rtot_q <= '0; ftot_q <= '0;
      fr_q <= FrType; long_q <= 1'b0; cok_q <= 1'b0; seq_q <= '0; crc_q <= '0;
      crcr_q <= '0; pos_q <= '0; tick_q <= '0; acc_q <= '0; hd_q <= HdName; hc_q <= '0;
    end else begin
      sess_q <= sess_d; eseq_q <= eseq_d; errc_q <= errc_d; rtot_q <= rtot_d;
      ftot_q <= ftot_d; fr_q <= fr_d; long_q <= long_d; cok_q <= cok_d; seq_q <= seq_d;
      crc_q <= crc_d; crcr_q <= crcr_d; pos_q <= pos_d; tick_q <= tick_d; acc_q <= acc_d;
      hd_q <= hd_d; hc_q <= hc_d;
    end
  end

  // a finished session never produces results
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sess_q == PhDone |-> bundle_o.cnt == '0) else $error("results after done");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bundle_o.cnt <= 3'd4) else $error("bundle overflow");
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(sess_q) == PhDone |-> sess_q == PhDone) else $error("left done");
endmodule
`default_nettype wire

// ===== hdl/ymcrc_back.sv =====
// Back end: bundle queue and serializer that hands out the results of each bundle one at a time.
`timescale 1ns / 1ps
`default_nettype none
module ymcrc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ymcrc_pkg::bundle_t bundle_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output ymcrc_pkg::res_t         res_o
);
  import ymcrc_pkg::*;

  // two-entry bundle queue
  bundle_t     q_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        rd_q, wr_q;
  logic [1:0]  sub_q, sub_d;
  logic        pop, wr_en;

  assign valid_o = (cnt_q != '0);
  assign res_o   = q_q[rd_q].res[sub_q];
  assign pop     = valid_o && !stall_i && (3'(sub_q) + 3'd1 == q_q[rd_q].cnt);
  assign wr_en   = push_i && (bundle_i.cnt != '0);
  assign ready_o = (cnt_q != 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    sub_d = sub_q;
    if (valid_o && !stall_i) sub_d = pop ? 2'd0 : sub_q + 2'd1;
    if (wr_en && !pop) cnt_d = cnt_q + 2'd1;
    else if (!wr_en && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) q_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; sub_q <= '0;
    end else begin
      cnt_q <= cnt_d; sub_q <= sub_d;
      if (wr_en) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (cnt_q != 2'd2)) else $error("queue overflow");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> res_o.last) else $error("bundle ends without last");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("bad count");
endmodule
`default_nettype wire

// ===== hdl/ymodem_crc_receiver.sv =====
// Top level of the YMODEM-CRC receiver: front end, bundle queue, result port.
// A request's results are registered into the bundle queue before they reach the
// output. Requests are taken one per cycle while the queue has room; results leave
// one per cycle while out_stall_i is low.
// The two-entry bundle queue sets when in_stall_o rises.
// Reset: asynchronous, active low; registers return to defaults, session idle.
`timescale 1ns / 1ps
`default_nettype none
module ymodem_crc_receiver #(
  parameter int unsigned NameMax = 64,
  parameter int unsigned SizeDigitsMax = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [23:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         operation_i,
  input  wire logic [7:0]   rx_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        kind_o,
  output logic [7:0]        value_byte_o,
  output logic [9:0]        data_index_o,
  output logic [10:0]       valid_count_o,
  output logic [31:0]       file_size_o,
  output logic [3:0]        status_o,
  output logic              last_o
);
  import ymcrc_pkg::*;

  bundle_t bundle;
  res_t    res;
  logic    ready, take;

  assign in_stall_o = !ready;
  assign take = in_valid_i && ready;

  ymcrc_front #(.NameMax(NameMax), .SizeDigitsMax(SizeDigitsMax)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .take_i(take), .operation_i, .rx_byte_i, .bundle_o(bundle)
  );

  ymcrc_back u_back (
    .clk_i, .rst_ni, .push_i(take), .bundle_i(bundle), .ready_o(ready),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .res_o(res)
  );

  assign kind_o        = res.kind;
  assign value_byte_o  = res.value_byte;
  assign data_index_o  = res.data_index;
  assign valid_count_o = res.valid_count;
  assign file_size_o   = res.file_size;
  assign status_o      = res.status;
  assign last_o        = res.last;
endmodule
`default_nettype wire

// ===== test/ymcrc_reply_checker.sv =====
// Checker for the YMODEM-CRC receiver: predicts every result and compares it.
`timescale 1ns / 1ps

package ymcrc_test_pkg;
  // CRC-16/XMODEM over one byte, bit serial, msb first
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ 16'h1021;
    end
    return acc;
  endfunction
endpackage

module ymcrc_reply_checker
  import ymcrc_pkg::*;
  import ymcrc_test_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [23:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  input  wire logic         in_stall_i,
  input  wire logic         operation_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_stall_i,
  input  wire logic [2:0]   kind_i,
  input  wire logic [7:0]   value_byte_i,
  input  wire logic [9:0]   data_index_i,
  input  wire logic [10:0]  valid_count_i,
  input  wire logic [31:0]  file_size_i,
  input  wire logic [3:0]   status_i,
  input  wire logic         last_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                request_count_o,
  output int                result_count_o
);
  // register copies
  logic [23:0] to_ticks;
  logic [7:0]  max_err, abort_a, abort_b;

  // protocol state
  sess_e       sess;
  frame_e      frame;
  hdr_e        hdr;
  logic [7:0]  exp_seq, err_cnt, seq_seen;
  logic [31:0] rcv_total, file_total, size_acc;
  logic        long_blk, comp_ok;
  logic [15:0] crc, crc_rx;
  logic [10:0] pos;
  logic [23:0] ticks;
  logic [6:0]  hdr_cnt;

  res_t step_q[$];     // results of the request being predicted
  res_t reply_q[$];    // results still owed by the block

  task add_res(kind_e k, logic [7:0] v, logic [9:0] ix, logic [10:0] vc,
               logic [31:0] fs, status_e st);
    res_t r;
    if (step_q.size() < MaxRes) begin
      r.kind = k; r.value_byte = v; r.data_index = ix; r.valid_count = vc;
      r.file_size = fs; r.status = st; r.last = 1'b0;
      step_q.push_back(r);
    end
  endtask

  task send_byte(logic [7:0] b, status_e st);
    add_res(KSend, b, '0, '0, '0, st);
  endtask

  task session_clear();
    sess = PhIdle; exp_seq = '0; err_cnt = '0; rcv_total = '0; file_total = '0;
  endtask

  task frame_reset();
    frame = FrType; long_blk = 1'b0; seq_seen = '0; comp_ok = 1'b0; crc = '0;
    crc_rx = '0; pos = '0; size_acc = '0; hdr = HdName; hdr_cnt = '0;
  endtask

  task end_session(status_e st);
    sess = PhDone;
    add_res(KDone, '0, '0, '0, '0, st);
  endtask

  task answer_error(status_e st);
    if (st == SMismatch) begin
      send_byte(BNak, st);
    end else if (st == SSender) begin
      send_byte(BAck, st);
      end_session(st);
    end else if (st == SUser) begin
      send_byte(BCan, st);
      send_byte(BCan, st);
      end_session(st);
    end else begin
      if (sess == PhBusy && err_cnt < 8'hFF) err_cnt = err_cnt + 1'b1;
      if (err_cnt > max_err) begin
        send_byte(BCan, st);
        send_byte(BCan, st);
        end_session(st);
      end else begin
        send_byte(BReq, st);
      end
    end
  endtask

  // header parse: filename, one skipped byte, decimal size
  task header_byte(logic [7:0] b);
    logic [35:0] acc;
    if (hdr == HdName) begin
      if (hdr_cnt >= 7'd64) begin
        hdr = HdSize; hdr_cnt = '0;
      end else if (b == 8'h00) begin
        hdr = (pos == 0) ? HdEmpty : HdSize;
        hdr_cnt = '0;
      end else begin
        hdr_cnt = hdr_cnt + 1'b1;
      end
    end else if (hdr == HdSize) begin
      if (hdr_cnt >= 7'd10 || b < 8'h30 || b > 8'h39) begin
        hdr = HdClosed;
      end else begin
        acc = size_acc * 36'd10 + (b - 8'h30);
        size_acc = (acc > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        hdr_cnt = hdr_cnt + 1'b1;
      end
    end
  endtask

  task close_block();
    status_e st;
    logic was_busy;
    logic [31:0] blk, rem, keep;
    st = SOk;
    was_busy = (sess == PhBusy);
    if (!comp_ok) st = SSeqInv;
    else if (crc != crc_rx) st = SCrc;
    else if (seq_seen != exp_seq) st = SMismatch;
    if (st == SOk && was_busy) begin
      if (rcv_total >= file_total) begin
        st = SInvalid;
      end else begin
        blk = long_blk ? 32'd1024 : 32'd128;
        rem = file_total - rcv_total;
        keep = (rem < blk) ? rem : blk;
        rcv_total = rcv_total + keep;
        err_cnt = '0;
        exp_seq = exp_seq + 1'b1;
        add_res(KCommit, '0, '0, keep[10:0], '0, SOk);
        send_byte(BAck, SOk);
      end
    end else if (st == SOk) begin
      if (hdr == HdEmpty) begin
        send_byte(BAck, SOk);
        end_session(SOk);
      end else if ((hdr == HdSize || hdr == HdClosed) && hdr_cnt > 0) begin
        file_total = size_acc;
        sess = PhBusy;
        exp_seq = exp_seq + 1'b1;
        add_res(KStart, '0, '0, '0, file_total, SOk);
        send_byte(BAck, SOk);
        send_byte(BReq, SOk);
      end else begin
        st = SSize;
      end
    end
    if (st != SOk) begin
      if (was_busy) add_res(KDiscard, '0, '0, '0, '0, st);
      answer_error(st);
    end
    frame_reset();
  endtask

  task take_byte(logic [7:0] b);
    case (frame)
      FrType: begin
        if (b == BSoh || b == BStx) begin
          frame_reset();
          long_blk = (b == BStx);
          frame = FrSeq;
        end else if (b == BEot) begin
          add_res(KEnd, '0, '0, '0, '0, SOk);
          send_byte(BAck, SOk);
          send_byte(BReq, SOk);
          session_clear();
        end else if (b == BCan) begin
          frame = FrCan;
        end else if (b == abort_a || b == abort_b) begin
          answer_error(SUser);
        end else begin
          answer_error(SUnknown);
        end
      end
      FrCan: begin
        frame_reset();
        answer_error((b == BCan) ? SSender : SUnknown);
      end
      FrSeq: begin
        seq_seen = b;
        frame = FrComp;
      end
      FrComp: begin
        comp_ok = ((b ^ 8'hFF) == seq_seen);
        pos = '0;
        crc = '0;
        frame = FrData;
      end
      FrData: begin
        crc = crc16_step(crc, b);
        if (sess == PhIdle) header_byte(b);
        else add_res(KData, b, pos[9:0], '0, '0, SOk);
        pos = pos + 1'b1;
        if (pos >= (long_blk ? 11'd1024 : 11'd128)) frame = FrCrcH;
      end
      FrCrcH: begin
        crc_rx = {b, 8'h00};
        frame = FrCrcL;
      end
      FrCrcL: begin
        crc_rx[7:0] = b;
        close_block();
      end
      default: frame_reset();
    endcase
  endtask

  task predict_request(logic op, logic [7:0] b);
    step_q.delete();
    if (sess == PhIdle || sess == PhBusy) begin
      if (!op) begin
        ticks = '0;
        take_byte(b);
      end else begin
        ticks = ticks + 1'b1;
        if (ticks >= to_ticks) begin
          ticks = '0;
          if (sess == PhBusy && frame >= FrData && frame <= FrCrcL)
            add_res(KDiscard, '0, '0, '0, '0, STimeout);
          frame_reset();
          answer_error(STimeout);
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) reply_q.push_back(step_q[i]);
  endtask

  task check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      to_ticks = 24'd1000; max_err = 8'd5; abort_a = 8'd65; abort_b = 8'd97;
      session_clear();
      frame_reset();
      ticks = '0;
      reply_q.delete();
      fail_count_o = 0; pending_o = 0; request_count_o = 0; result_count_o = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTimeout: to_ticks = cfg_data_i;
          CfgMaxErr:  max_err = cfg_data_i[7:0];
          CfgAbort1:  abort_a = cfg_data_i[7:0];
          CfgAbort2:  abort_b = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // result side
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (reply_q.size() == 0) begin
          $error("unexpected result: kind %0d value %0d", kind_i, value_byte_i);
          fail_count_o++;
        end else begin
          want = reply_q.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("value_byte", want.value_byte, value_byte_i);
          check_field("data_index", want.data_index, data_index_i);
          check_field("valid_count", want.valid_count, valid_count_i);
          check_field("file_size", want.file_size, file_size_i);
          check_field("status", want.status, status_i);
          check_field("last", want.last, last_i);
        end
      end
      // request side
      if (in_valid_i && !in_stall_i) begin
        request_count_o++;
        predict_request(operation_i, rx_byte_i);
      end
      pending_o = reply_q.size();
    end
  end
endmodule

// ===== test/ymodem_crc_receiver_test.sv =====
// Top of the YMODEM-CRC receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ymodem_crc_receiver_test;
  import ymcrc_pkg::*;
  import ymcrc_test_pkg::*;

  // ways a frame can be spoiled
  localparam int FlawNone    = 0;
  localparam int FlawComp    = 1;
  localparam int FlawCrc     = 2;
  localparam int FlawTimeout = 3;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;
  logic        in_valid, in_stall, operation;
  logic [7:0]  rx_byte;
  logic        out_valid, out_stall;
  logic [2:0]  kind;
  logic [7:0]  value_byte;
  logic [9:0]  data_index;
  logic [10:0] valid_count;
  logic [31:0] file_size;
  logic [3:0]  status;
  logic        last;
  int          fails, pending, requests, results;

  logic [7:0]  payload [1024];
  bit          idle_on, hold_req, press_pending, force_long, tb_busy;
  int          sent, cur_to;
  logic [7:0]  tb_seq;
  longint      tb_size, tb_total;

  ymodem_crc_receiver dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .value_byte_o(value_byte), .data_index_o(data_index),
    .valid_count_o(valid_count), .file_size_o(file_size), .status_o(status),
    .last_o(last)
  );

  ymcrc_reply_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .operation_i(operation), .rx_byte_i(rx_byte),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .kind_i(kind), .value_byte_i(value_byte), .data_index_i(data_index),
    .valid_count_i(valid_count), .file_size_i(file_size), .status_i(status),
    .last_i(last),
    .fail_count_o(fails), .pending_o(pending),
    .request_count_o(requests), .result_count_o(results)
  );

  always #4 clk = ~clk;

  // result side stall: random bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one request, held until accepted
  task put(logic op, logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rx_byte   <= b;
    sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every owed result is out, then let the block settle
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_regs(logic [23:0] to, logic [7:0] me, logic [7:0] a1, logic [7:0] a2);
    drain();
    cfg_we <= 1'b1; cfg_idx <= CfgTimeout; cfg_data <= to;
    @(posedge clk);
    cfg_idx <= CfgMaxErr; cfg_data <= {16'h0, me};
    @(posedge clk);
    cfg_idx <= CfgAbort1; cfg_data <= {16'h0, a1};
    @(posedge clk);
    cfg_idx <= CfgAbort2; cfg_data <= {16'h0, a2};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_to = int'(to);
  endtask

  // one framed block from payload, possibly spoiled
  task send_frame(bit long_f, logic [7:0] seq, int flaw);
    int n, cut;
    logic [15:0] c;
    n = long_f ? 1024 : 128;
    cut = $urandom_range(0, n - 1);
    put(1'b0, long_f ? BStx : BSoh);
    put(1'b0, seq);
    put(1'b0, (flaw == FlawComp) ? seq : ~seq);
    c = '0;
    for (int i = 0; i < n; i++) begin
      put(1'b0, payload[i]);
      c = crc16_step(c, payload[i]);
      if (i == cut) begin
        if (flaw == FlawTimeout) begin
          repeat (cur_to) put(1'b1, 8'($urandom_range(0, 255)));
          return;
        end else if (cur_to >= 3 && $urandom_range(0, 3) == 0) begin
          put(1'b1, 8'($urandom_range(0, 255)));
        end
      end
    end
    put(1'b0, c[15:8]);
    put(1'b0, (flaw == FlawCrc) ? (c[7:0] ^ 8'h01) : c[7:0]);
  endtask

  // one random protocol sequence, mostly well formed
  task random_sequence();
    int r, p, flaw, mode, nlen;
    string digits;
    logic [7:0] b, seq;
    bit long_f;
    r = $urandom_range(0, 99);
    idle_on = ($urandom_range(0, 3) != 0);
    if (r < 18 && !tb_busy) begin
      // header block: name, terminator or skipped byte, size digits
      foreach (payload[i]) payload[i] = 8'h00;
      nlen = $urandom_range(1, 70);
      mode = $urandom_range(0, 9);
      if (nlen >= 64) begin
        for (int i = 0; i < 64; i++) payload[i] = 8'($urandom_range(1, 255));
        payload[64] = 8'($urandom_range(0, 255));
        p = 65;
      end else begin
        for (int i = 0; i < nlen; i++) payload[i] = 8'($urandom_range(1, 255));
        p = nlen + 1;
      end
      if (mode == 0) begin
        digits = "";
        tb_size = -1;
      end else if (mode == 1) begin
        digits = "99999999999";
        tb_size = 64'hFFFF_FFFF;
      end else begin
        tb_size = (mode < 4) ? $urandom_range(1000, 3000) : $urandom_range(0, 400);
        digits = $sformatf("%0d", tb_size);
      end
      for (int k = 0; k < digits.len(); k++) payload[p + k] = digits[k];
      payload[p + digits.len()] = " ";
      flaw = ($urandom_range(0, 9) == 0) ? FlawCrc : FlawNone;
      send_frame(1'b0, 8'h00, flaw);
      if (flaw == FlawNone && mode != 0) begin
        tb_busy = 1'b1; tb_seq = 8'd1; tb_total = 0;
      end
    end else if (r < 60) begin
      // data block
      long_f = force_long;
      force_long = 1'b0;
      if (press_pending) begin
        hold_req = 1'b1;
        press_pending = 1'b0;
      end
      foreach (payload[i]) payload[i] = 8'($urandom_range(0, 255));
      p = $urandom_range(0, 99);
      if (p < 10) flaw = FlawComp;
      else if (p < 20) flaw = FlawCrc;
      else if (p < 26 && cur_to <= 8) flaw = FlawTimeout;
      else flaw = FlawNone;
      seq = tb_seq;
      if ($urandom_range(0, 9) == 0) seq = tb_seq + 8'($urandom_range(1, 255));
      send_frame(long_f, seq, flaw);
      if (tb_busy && flaw == FlawNone && seq == tb_seq && tb_total < tb_size) begin
        tb_total = tb_total + (long_f ? 1024 : 128);
        tb_seq++;
      end
    end else if (r < 66) begin
      put(1'b0, BEot);
      tb_busy = 1'b0;
      tb_seq = 8'h00;
    end else if (r < 72) begin
      // cancel not followed by a second cancel
      b = 8'($urandom_range(0, 255));
      if (b == BCan) b = 8'h00;
      put(1'b0, BCan);
      put(1'b0, b);
    end else if (r < 84) begin
      repeat ($urandom_range(1, 4)) put(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      // stray byte outside any frame
      do b = 8'($urandom_range(0, 255));
      while (b == BSoh || b == BStx || b == BCan || b == BEot);
      put(1'b0, b);
    end
  endtask

  // stimulus
  initial begin
    clk = 1'b0; rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = CfgTimeout; cfg_data = '0;
    in_valid = 1'b0; operation = 1'b0; rx_byte = '0;
    idle_on = 1'b1; hold_req = 1'b0; press_pending = 1'b0; force_long = 1'b0;
    tb_busy = 1'b0; tb_seq = '0; tb_size = 0; tb_total = 0; sent = 0; cur_to = 1000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: shortest timeout, framing bytes double as abort bytes
    write_regs(24'd1, 8'd255, BSoh, BCan);
    put(1'b1, 8'hA5);
    put(1'b0, 8'hFF);
    put(1'b0, 8'h00);
    put(1'b0, BCan); put(1'b0, 8'h7E);
    put(1'b0, BEot);
    put(1'b0, BSoh); put(1'b0, 8'h00); put(1'b1, 8'h5A);
    put(1'b0, BStx); put(1'b0, 8'h00); put(1'b0, 8'hFF); put(1'b0, 8'h41);
    put(1'b1, 8'h00);
    put(1'b0, 8'h80);

    // random, short timeout, with one long output hold-off
    write_regs(24'd3, 8'd255, BSoh, BCan);
    sent = 0;
    press_pending = 1'b1;
    while (sent < 215) random_sequence();

    // random, longest timeout
    write_regs(24'hFF_FFFF, 8'd200, BStx, BEot);
    while (sent < 430 || force_long) random_sequence();

    // no idling from here; zero error budget, abort on a zero byte
    idle_on = 1'b0;
    write_regs(24'd1000, 8'd0, 8'd0, 8'd255);
    idle_on = 1'b0;
    put(1'b1, 8'h33);
    put(1'b0, BEot);
    put(1'b0, 8'h00);
    put(1'b0, BSoh);
    put(1'b1, 8'hC3);
    put(1'b0, 8'hFF);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests and %0d results: headers, data blocks, EOT, cancels,",
             requests, results);
    $display("timeouts, corrupted frames and a user abort under four register settings");
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/ymcrc_pkg.sv
hdl/ymcrc_front.sv
hdl/ymcrc_back.sv
hdl/ymodem_crc_receiver.sv
test/ymcrc_reply_checker.sv
test/ymodem_crc_receiver_test.sv
